@@ design/sbb_pkg.sv @@
`timescale 1ns / 1ps

package sbb_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int BOX_W    = 6;
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 14;
    localparam int POS_W    = 7;
    // The radius of a 6-bit box is at most 31, and a flush distance at most 62.
    localparam int RAD_W    = 5;
    localparam int DIST_W   = 6;

    // Default for the largest radius that the delay memory is sized for.
    localparam int unsigned MAX_RADIUS_DEFAULT = 31;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // The reciprocal multiply uses ceil(2^RECIP_SHIFT / box_size).
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [POS_W-1:0]    POS_MAX = '1;
    localparam logic [SAMPLE_W-1:0] OUT_MAX = '1;

    // One classified input item, as the front hands it to the back.
    typedef struct packed {
        logic [SAMPLE_W-1:0] alpha;
        logic                last;
        logic                drop;
        logic                emit;
        logic [RAD_W-1:0]    flush_cnt;
        logic [POS_W-1:0]    pos;
    } cmd_t;

    // One window sum on its way to the divider.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic             row_end;
    } sum_beat_t;

    typedef enum logic {
        SEQ_ITEM,
        SEQ_FLUSH
    } seq_state_t;

    // Window radius: (box_size - 1) / 2, with a zero box treated as one,
    // limited to the largest radius the delay memory holds.
    function automatic logic [RAD_W-1:0] radius(input logic [BOX_W-1:0] box_size,
                                                input int unsigned max_radius);
        logic [BOX_W-1:0] bs;
        logic [BOX_W-1:0] half;
        bs   = (box_size == '0) ? BOX_W'(1) : box_size;
        half = (bs - BOX_W'(1)) >> 1;
        if (int'(half) > int'(max_radius))
        begin
            half = BOX_W'(max_radius);
        end
        return RAD_W'(half);
    endfunction

endpackage

@@ design/sliding_box_blur_line.sv @@
`timescale 1ns / 1ps

// Box filter along one row of 8-bit alpha samples, using a running sum.
// The slave stream carries one sample per transaction in s_tdata, with
// s_tlast on the final sample of a row. The master stream returns blurred
// samples in m_tdata, floor(window sum / box_size) saturated to 255, with
// m_tlast on the last output of the row. The box width is written through
// cfg_wr_en / cfg_wr_data and resets to 1; the user must write it only
// while the stream is idle; the block does not enforce it. Output j
// leaves after sample j+R arrives, R = (box_size-1)/2. One sample is
// taken per cycle while the command queue has room; the last sample of a
// row is followed by min(R, row length) flush steps, one per output, as a
// single delay-memory read port serves both the window update and the
// flush. Reset clears the row position, the running sum, the command
// queue and all valid flags; the delay memory is not cleared. While an
// output waits on m_tready, the output register and the back pipeline
// hold; the four-entry command queue keeps taking samples until it fills.
module sliding_box_blur_line #(
    parameter int unsigned MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sbb_pkg::BOX_W-1:0]     cfg_wr_data,  // box_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbb_pkg::SAMPLE_W-1:0]  s_tdata,      // [7:0] alpha_in
    input  logic                          s_tlast,      // row_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbb_pkg::SAMPLE_W-1:0]  m_tdata,      // [7:0] alpha_out
    output logic                          m_tlast       // row_end
);

    logic [sbb_pkg::BOX_W-1:0] box_size_reg;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    sbb_pkg::cmd_t             q_cmd;
    sbb_pkg::cmd_t             q_head;
    sbb_pkg::sum_beat_t        beat;
    logic                      advance;

    // Box width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_size_reg <= sbb_pkg::BOX_W'(1);
        end
        else if (cfg_wr_en)
        begin
            box_size_reg <= cfg_wr_data;
        end
    end

    sbb_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_size (box_size_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    sbb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sbb_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_size (box_size_reg),
        .advance  (advance),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .beat     (beat)
    );

    sbb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_size (box_size_reg),
        .beat     (beat),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/sbb_front.sv @@
`timescale 1ns / 1ps

module sbb_front #(
    parameter int unsigned MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sbb_pkg::BOX_W-1:0]      box_size,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbb_pkg::SAMPLE_W-1:0]   s_tdata,   // [7:0] alpha_in
    input  logic                           s_tlast,   // row_last
    input  logic                           q_full,
    output logic                           q_push,
    output sbb_pkg::cmd_t                  q_cmd
);

    logic [sbb_pkg::POS_W-1:0] pos_reg;
    logic [sbb_pkg::POS_W-1:0] pos_next;
    logic [sbb_pkg::RAD_W-1:0] r;
    logic [sbb_pkg::POS_W:0]   pos_inc;

    assign r       = sbb_pkg::radius(box_size, MAX_RADIUS);
    assign pos_inc = {1'b0, pos_reg} + (sbb_pkg::POS_W + 1)'(1);

    // The queue takes a transaction whenever it has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the item against the current position in the row.
    always_comb
    begin
        q_cmd.alpha = s_tdata;
        q_cmd.last  = s_tlast;
        q_cmd.pos   = pos_reg;
        // The oldest sample leaves the window once a full box has been seen.
        q_cmd.drop  = pos_reg >= sbb_pkg::POS_W'({r, 1'b1});
        // A centered output becomes ready once r samples lie behind it.
        q_cmd.emit  = pos_reg >= sbb_pkg::POS_W'(r);
        // At the row end, min(r, pos + 1) outputs remain to be flushed.
        if ((sbb_pkg::POS_W + 1)'(r) < pos_inc)
        begin
            q_cmd.flush_cnt = r;
        end
        else
        begin
            q_cmd.flush_cnt = sbb_pkg::RAD_W'(pos_inc);
        end
    end

    // Row position saturates for long rows and restarts after the last item.
    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (s_tlast)
            begin
                pos_next = '0;
            end
            else if (pos_reg != sbb_pkg::POS_MAX)
            begin
                pos_next = pos_inc[sbb_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ design/sbb_queue.sv @@
`timescale 1ns / 1ps

module sbb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbb_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sbb_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = $clog2(sbb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sbb_pkg::QUEUE_DEPTH + 1);

    sbb_pkg::cmd_t      entry_reg [sbb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == CNT_W'(sbb_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointers wrap over the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sbb_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sbb_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/sbb_back.sv @@
`timescale 1ns / 1ps

module sbb_back #(
    parameter int unsigned MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sbb_pkg::BOX_W-1:0]  box_size,
    input  logic                       advance,
    input  logic                       q_empty,
    input  sbb_pkg::cmd_t              q_head,
    output logic                       q_pop,
    output sbb_pkg::sum_beat_t         beat
);

    // The delay memory keeps at least 2*MAX_RADIUS+1 samples, addressed
    // by a wrapping write pointer.
    localparam int DEPTH    = 2 * MAX_RADIUS + 2;
    localparam int AW       = $clog2(DEPTH);
    localparam int MEM_SIZE = 2 ** AW;

    logic [sbb_pkg::SAMPLE_W-1:0] delay_mem [MEM_SIZE];

    sbb_pkg::seq_state_t          state_reg;
    sbb_pkg::seq_state_t          state_next;
    logic [AW-1:0]                wptr_reg;
    logic [AW-1:0]                wptr_next;
    logic [sbb_pkg::RAD_W-1:0]    cnt_reg;
    logic [sbb_pkg::RAD_W-1:0]    cnt_next;
    logic [sbb_pkg::DIST_W-1:0]   dist_reg;
    logic [sbb_pkg::DIST_W-1:0]   dist_next;
    logic [sbb_pkg::POS_W-1:0]    pos_reg;
    logic [sbb_pkg::POS_W-1:0]    pos_next;
    logic [sbb_pkg::RAD_W-1:0]    r;

    logic                         issue;
    logic                         wr_en;
    logic [AW-1:0]                raddr;
    logic [sbb_pkg::SAMPLE_W-1:0] op_add;
    logic                         op_sub;
    logic                         op_emit;
    logic                         op_end;

    logic                         b_valid_reg;
    logic [sbb_pkg::SAMPLE_W-1:0] b_add_reg;
    logic                         b_sub_reg;
    logic                         b_emit_reg;
    logic                         b_end_reg;
    logic [sbb_pkg::SAMPLE_W-1:0] rd_reg;
    logic [sbb_pkg::SUM_W-1:0]    sum_reg;
    logic [sbb_pkg::SUM_W-1:0]    sum_new;
    logic                         beat_valid_reg;
    logic [sbb_pkg::SUM_W-1:0]    beat_sum_reg;
    logic                         beat_end_reg;

    assign r = sbb_pkg::radius(box_size, MAX_RADIUS);

    // Sequencer: one step per cycle while the pipeline advances, either a new item or one flush output.
    always_comb
    begin
        state_next = state_reg;
        wptr_next  = wptr_reg;
        cnt_next   = cnt_reg;
        dist_next  = dist_reg;
        pos_next   = pos_reg;
        q_pop      = 1'b0;
        issue      = 1'b0;
        wr_en      = 1'b0;
        raddr      = wptr_reg - AW'(dist_reg);
        op_add     = '0;
        op_sub     = 1'b0;
        op_emit    = 1'b0;
        op_end     = 1'b0;
        case (state_reg)
            sbb_pkg::SEQ_ITEM:
            begin
                if (advance && !q_empty)
                begin
                    q_pop     = 1'b1;
                    issue     = 1'b1;
                    wr_en     = 1'b1;
                    wptr_next = wptr_reg + AW'(1);
                    // The sample 2r+1 places behind the new one leaves the window.
                    raddr     = wptr_reg + AW'(1) - AW'({r, 1'b1});
                    op_add    = q_head.alpha;
                    op_sub    = q_head.drop;
                    op_emit   = q_head.emit;
                    op_end    = q_head.last && (q_head.flush_cnt == '0);
                    if (q_head.last && (q_head.flush_cnt != '0))
                    begin
                        state_next = sbb_pkg::SEQ_FLUSH;
                        cnt_next   = q_head.flush_cnt;
                        dist_next  = sbb_pkg::DIST_W'(q_head.flush_cnt)
                                     + sbb_pkg::DIST_W'(r);
                        pos_next   = q_head.pos;
                    end
                end
            end
            sbb_pkg::SEQ_FLUSH:
            begin
                if (advance)
                begin
                    issue     = 1'b1;
                    raddr     = wptr_reg - AW'(dist_reg);
                    // Only samples of this row are taken out of the sum.
                    op_sub    = sbb_pkg::POS_W'(dist_reg) <= pos_reg;
                    op_emit   = 1'b1;
                    op_end    = cnt_reg == sbb_pkg::RAD_W'(1);
                    cnt_next  = cnt_reg - sbb_pkg::RAD_W'(1);
                    dist_next = dist_reg - sbb_pkg::DIST_W'(1);
                    if (cnt_reg == sbb_pkg::RAD_W'(1))
                    begin
                        state_next = sbb_pkg::SEQ_ITEM;
                    end
                end
            end
            default:
            begin
                state_next = sbb_pkg::SEQ_ITEM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbb_pkg::SEQ_ITEM;
            wptr_reg  <= '0;
            cnt_reg   <= '0;
            dist_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            cnt_reg   <= cnt_next;
            dist_reg  <= dist_next;
            pos_reg   <= pos_next;
        end
    end

    // Delay memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            delay_mem[wptr_next] <= q_head.alpha;
        end
        if (advance)
        begin
            rd_reg <= delay_mem[raddr];
        end
    end

    // Step register in front of the running sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && issue)
        begin
            b_add_reg  <= op_add;
            b_sub_reg  <= op_sub;
            b_emit_reg <= op_emit;
            b_end_reg  <= op_end;
        end
    end

    // Running sum: add the new sample and drop the one leaving, wrapping.
    assign sum_new = sum_reg + sbb_pkg::SUM_W'(b_add_reg)
                     - (b_sub_reg ? sbb_pkg::SUM_W'(rd_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            beat_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            beat_valid_reg <= b_valid_reg && b_emit_reg;
            if (b_valid_reg)
            begin
                sum_reg <= b_end_reg ? '0 : sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            beat_sum_reg <= sum_new;
            beat_end_reg <= b_end_reg;
        end
    end

    assign beat.valid   = beat_valid_reg;
    assign beat.sum     = beat_sum_reg;
    assign beat.row_end = beat_end_reg;

endmodule

@@ design/sbb_div.sv @@
`timescale 1ns / 1ps

module sbb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbb_pkg::BOX_W-1:0]     box_size,
    input  sbb_pkg::sum_beat_t            beat,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbb_pkg::SAMPLE_W-1:0]  m_tdata,   // [7:0] alpha_out
    output logic                          m_tlast    // row_end
);

    localparam int NUM_BOX = 2 ** sbb_pkg::BOX_W;
    localparam int QUOT_W  = sbb_pkg::PROD_W - sbb_pkg::RECIP_SHIFT;

    logic [sbb_pkg::RECIP_W-1:0]  recip_tab [NUM_BOX];
    logic                         p_valid_reg;
    logic [sbb_pkg::PROD_W-1:0]   prod_reg;
    logic                         p_end_reg;
    logic [QUOT_W-1:0]            quot;
    logic                         out_valid_reg;
    logic [sbb_pkg::SAMPLE_W-1:0] out_data_reg;
    logic                         out_last_reg;

    // Reciprocal table: ceil(2^20 / d). For sums below 2^14 and d below 64
    // the product shifted down is exactly the floor quotient.
    for (genvar g = 0; g < NUM_BOX; g++)
    begin : g_recip
        localparam int unsigned DIVISOR = (g == 0) ? 1 : g;
        localparam int unsigned VALUE   =
            ((1 << sbb_pkg::RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
        assign recip_tab[g] = sbb_pkg::RECIP_W'(VALUE);
    end

    // The whole pipeline moves while the output register is free or drained.
    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg   <= beat.valid;
            out_valid_reg <= p_valid_reg;
        end
    end

    // Multiply stage.
    always_ff @(posedge clk)
    begin
        if (advance && beat.valid)
        begin
            prod_reg  <= sbb_pkg::PROD_W'(beat.sum)
                         * sbb_pkg::PROD_W'(recip_tab[box_size]);
            p_end_reg <= beat.row_end;
        end
    end

    // Shift down and saturate quotients above the sample range.
    assign quot = prod_reg[sbb_pkg::PROD_W-1:sbb_pkg::RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (advance && p_valid_reg)
        begin
            if (quot > QUOT_W'(sbb_pkg::OUT_MAX))
            begin
                out_data_reg <= sbb_pkg::OUT_MAX;
            end
            else
            begin
                out_data_reg <= quot[sbb_pkg::SAMPLE_W-1:0];
            end
            out_last_reg <= p_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_CYCLES = 100;
    localparam int HOLD_CYCLES  = 80;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 6;
    localparam int LONG_ROW     = 130;

    // One blurred output pixel as the block should deliver it.
    typedef struct packed {
        logic [sbb_pkg::SAMPLE_W-1:0] alpha;
        logic                         row_end;
    } blur_pixel_t;

    // Running-sum box filter predictor with the queue of pixels still due.
    class blur_scoreboard;
        logic [sbb_pkg::SAMPLE_W-1:0] recent [63];
        logic [sbb_pkg::SUM_W-1:0]    run_sum;
        logic [sbb_pkg::POS_W-1:0]    row_pos;
        logic [sbb_pkg::BOX_W-1:0]    box;
        blur_pixel_t                  awaited_pixels [$];
        int                           matched;

        function new();
            for (int i = 0; i < 63; i++)
            begin
                recent[i] = '0;
            end
            run_sum = '0;
            row_pos = '0;
            box     = sbb_pkg::BOX_W'(1);
            matched = 0;
        endfunction

        function void set_box(logic [sbb_pkg::BOX_W-1:0] value);
            box = value;
        endfunction

        // A zero box behaves as a box of one.
        function int divisor();
            return (box == '0) ? 1 : int'(box);
        endfunction

        function int radius_now();
            return (divisor() - 1) / 2;
        endfunction

        function logic [sbb_pkg::SAMPLE_W-1:0] blurred();
            int q;
            q = int'(run_sum) / divisor();
            return (q > 255) ? sbb_pkg::OUT_MAX : sbb_pkg::SAMPLE_W'(q);
        endfunction

        // Update the window with one accepted sample and queue the outputs it causes.
        function void take_sample(logic [sbb_pkg::SAMPLE_W-1:0] x, logic last);
            int r;
            int pos;
            int start;
            int d;
            blur_pixel_t px;
            r   = radius_now();
            pos = int'(row_pos);
            if (pos >= 2 * r + 1)
            begin
                run_sum = run_sum - sbb_pkg::SUM_W'(recent[2 * r]);
            end
            for (int i = 62; i > 0; i--)
            begin
                recent[i] = recent[i - 1];
            end
            recent[0] = x;
            run_sum   = run_sum + sbb_pkg::SUM_W'(x);
            px.row_end = 1'b0;
            if (pos >= r)
            begin
                px.alpha = blurred();
                awaited_pixels.push_back(px);
            end
            if (last)
            begin
                // Flush the outputs whose windows reach past the row end.
                start = pos - r + 1;
                if (start < 0)
                begin
                    start = 0;
                end
                for (int j = start; j <= pos; j++)
                begin
                    d = pos - j + 1 + r;
                    if (d <= pos)
                    begin
                        run_sum = run_sum - sbb_pkg::SUM_W'(recent[d]);
                    end
                    px.alpha = blurred();
                    awaited_pixels.push_back(px);
                end
                awaited_pixels[awaited_pixels.size() - 1].row_end = 1'b1;
                run_sum = '0;
                row_pos = '0;
            end
            else if (row_pos != sbb_pkg::POS_MAX)
            begin
                row_pos = row_pos + 1'b1;
            end
        endfunction

        // Compare one output transaction with the oldest pixel due.
        function string match_output(logic [sbb_pkg::SAMPLE_W-1:0] alpha, logic row_end);
            blur_pixel_t want;
            if (awaited_pixels.size() == 0)
            begin
                return $sformatf("unexpected output alpha=%0d row_end=%0b", alpha, row_end);
            end
            want = awaited_pixels.pop_front();
            matched++;
            if (alpha !== want.alpha || row_end !== want.row_end)
            begin
                return $sformatf("output %0d: alpha %0d (want %0d), row_end %0b (want %0b)",
                                 matched, alpha, want.alpha, row_end, want.row_end);
            end
            return "";
        endfunction
    endclass

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [sbb_pkg::BOX_W-1:0]    cfg_wr_data = sbb_pkg::BOX_W'(1);
    logic                         s_tvalid    = 1'b0;
    logic                         s_tready;
    logic [sbb_pkg::SAMPLE_W-1:0] s_tdata     = '0;
    logic                         s_tlast     = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready    = 1'b0;
    logic [sbb_pkg::SAMPLE_W-1:0] m_tdata;
    logic                         m_tlast;

    blur_scoreboard sb;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    mismatches    = 0;
    int    cycle_count   = 0;
    logic  hold_req      = 1'b0;
    logic  hold_taken    = 1'b0;
    int    hold_left     = 0;
    string check_msg;

    sliding_box_blur_line DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("sliding_box_blur_line test failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every output transaction against the predicted pixels.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            check_msg = sb.match_output(m_tdata, m_tlast);
            if (check_msg != "")
            begin
                report_mismatch(check_msg);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // The register is only written while no output is outstanding.
    task automatic write_box(input int value);
        cfg_wr_data <= sbb_pkg::BOX_W'(value);
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_box(sbb_pkg::BOX_W'(value));
    endtask

    // Offer one sample, with random sender gaps, and wait for its transaction.
    task automatic send_item(input logic [sbb_pkg::SAMPLE_W-1:0] alpha, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= alpha;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.take_sample(alpha, last);
    endtask

    // Stop offering, wait until every pixel due has arrived, then let the pipe drain.
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    function automatic logic [sbb_pkg::SAMPLE_W-1:0] pick_alpha();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return sbb_pkg::OUT_MAX;
            default: return sbb_pkg::SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Row lengths: at most the radius, around one full window, or arbitrary.
    function automatic int pick_row_len(input int r);
        int len;
        case ($urandom_range(0, 3))
            0: len = $urandom_range(1, (r > 0) ? r : 1);
            1: len = 2 * r + $urandom_range(0, 3);
            2: len = $urandom_range(1, 8);
            default: len = $urandom_range(1, 40);
        endcase
        return (len < 1) ? 1 : len;
    endfunction

    task automatic send_row(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(pick_alpha(), i == len - 1);
        end
    endtask

    // Stimulus: directed rows, then random phases with varied pacing.
    initial
    begin : stimulus
        int sent;
        int len;
        int box_val;
        logic paused;
        sb = new();
        send_idle_pct = 24;
        recv_idle_pct = 47;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero box acts as a box of one.
        write_box(0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd170, 1'b1);
        settle(QUIET_CYCLES);

        // Widest box: a single-sample row, then a short row, both all flush.
        write_box(63);
        send_item(8'd255, 1'b1);
        send_item(8'd85, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b1);
        settle(QUIET_CYCLES);

        // Even box: radius zero with a divisor of two.
        write_box(2);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd1, 1'b1);
        settle(QUIET_CYCLES);

        // Growing the box mid-row makes the sum wrap and the quotient saturate.
        write_box(1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        settle(QUIET_CYCLES);
        write_box(3);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b1);
        settle(QUIET_CYCLES);

        write_box(3);
        send_item(8'd128, 1'b0);
        send_item(8'd127, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd1, 1'b1);
        settle(QUIET_CYCLES);

        // Random phases: two per pacing mode.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: box_val = 63;
                2: box_val = 1;
                4: box_val = 2;
                5: box_val = 63;
                default: box_val = $urandom_range(0, 63);
            endcase
            write_box(box_val);
            if (ph == 5)
            begin
                hold_req <= 1'b1;
            end
            sent   = 0;
            paused = 1'b0;
            if (ph == 5)
            begin
                // Long row drives the position count into saturation.
                send_row(LONG_ROW);
                sent = LONG_ROW;
            end
            while (sent < PHASE_ITEMS)
            begin
                len = pick_row_len(sb.radius_now());
                if (len > PHASE_ITEMS - sent)
                begin
                    len = PHASE_ITEMS - sent;
                end
                send_row(len);
                sent += len;
                if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    settle(0);
                end
            end
            settle(QUIET_CYCLES);
        end

        if (mismatches == 0)
        begin
            $display("sliding_box_blur_line test passed");
        end
        else
        begin
            $display("sliding_box_blur_line test failed");
        end
        $finish;
    end

endmodule
